[hdl/owbm_pkg.sv]
package owbm_pkg;

    localparam int TimeW   = 10;
    localparam int ByteW   = 8;
    localparam int RegIdxW = 3;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_TAIL,
        PH_WR_START,
        PH_WR_HOLD,
        PH_RD_START,
        PH_RD_WAIT,
        PH_RD_TAIL
    } phase_t;

    typedef enum logic [1:0] {
        MODE_TICK,
        MODE_RESET,
        MODE_WRITE,
        MODE_READ
    } mode_t;

    localparam logic [RegIdxW-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [RegIdxW-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [RegIdxW-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [RegIdxW-1:0] REG_SLOT_START    = 3'd3;
    localparam logic [RegIdxW-1:0] REG_WRITE_SLOT    = 3'd4;
    localparam logic [RegIdxW-1:0] REG_READ_SAMPLE   = 3'd5;
    localparam logic [RegIdxW-1:0] REG_READ_TAIL     = 3'd6;

    localparam logic [TimeW-1:0] RESET_LOW_DEF     = 10'd480;
    localparam logic [TimeW-1:0] PRESENCE_WAIT_DEF = 10'd60;
    localparam logic [TimeW-1:0] RESET_TAIL_DEF    = 10'd420;
    localparam logic [TimeW-1:0] SLOT_START_DEF    = 10'd1;
    localparam logic [TimeW-1:0] WRITE_SLOT_DEF    = 10'd60;
    localparam logic [TimeW-1:0] READ_SAMPLE_DEF   = 10'd14;
    localparam logic [TimeW-1:0] READ_TAIL_DEF     = 10'd45;

    typedef struct packed {
        logic [TimeW-1:0] reset_low;
        logic [TimeW-1:0] presence_wait;
        logic [TimeW-1:0] reset_tail;
        logic [TimeW-1:0] slot_start;
        logic [TimeW-1:0] write_slot;
        logic [TimeW-1:0] read_sample;
        logic [TimeW-1:0] read_tail;
    } timing_t;

    typedef struct packed {
        mode_t            mode;
        logic [ByteW-1:0] data_byte;
        logic             line_level;
    } item_t;

    // packed from lowest bit: drive_low, busy_res, done_res, read_data,
    // no_presence, command_rejected
    typedef struct packed {
        logic             command_rejected;
        logic             no_presence;
        logic [ByteW-1:0] read_data;
        logic             done_res;
        logic             busy_res;
        logic             drive_low;
    } result_t;

    localparam int ResultW = $bits(result_t);

endpackage

[hdl/owbm_cfg.sv]
module owbm_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [owbm_pkg::RegIdxW-1:0]  cfg_addr,
    input  logic [owbm_pkg::TimeW-1:0]    cfg_data,
    output owbm_pkg::timing_t             timing
);
    import owbm_pkg::*;

    timing_t timing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.reset_low     <= RESET_LOW_DEF;
            timing_reg.presence_wait <= PRESENCE_WAIT_DEF;
            timing_reg.reset_tail    <= RESET_TAIL_DEF;
            timing_reg.slot_start    <= SLOT_START_DEF;
            timing_reg.write_slot    <= WRITE_SLOT_DEF;
            timing_reg.read_sample   <= READ_SAMPLE_DEF;
            timing_reg.read_tail     <= READ_TAIL_DEF;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_RESET_LOW:     timing_reg.reset_low     <= cfg_data;
                REG_PRESENCE_WAIT: timing_reg.presence_wait <= cfg_data;
                REG_RESET_TAIL:    timing_reg.reset_tail    <= cfg_data;
                REG_SLOT_START:    timing_reg.slot_start    <= cfg_data;
                REG_WRITE_SLOT:    timing_reg.write_slot    <= cfg_data;
                REG_READ_SAMPLE:   timing_reg.read_sample   <= cfg_data;
                REG_READ_TAIL:     timing_reg.read_tail     <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign timing = timing_reg;

endmodule

[hdl/owbm_fsm.sv]
module owbm_fsm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  owbm_pkg::item_t     item,
    input  owbm_pkg::timing_t   timing,
    output owbm_pkg::result_t   res
);
    import owbm_pkg::*;

    phase_t             phase_reg,       phase_next;
    logic [TimeW-1:0]   timer_reg,       timer_next;
    logic [2:0]         bit_count_reg,   bit_count_next;
    logic [ByteW-1:0]   shift_reg,       shift_next;
    logic               first_reg,       first_next;
    logic               presence_reg,    presence_next;

    logic [TimeW-1:0]   cur_len;
    logic [TimeW-1:0]   timer_inc;
    logic               done;
    logic               rejected;
    logic [ByteW-1:0]   rdata;
    logic               drive;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            first_reg     <= 1'b0;
            presence_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            first_reg     <= first_next;
            presence_reg  <= presence_next;
        end
    end

    always_comb
    begin
        case (phase_reg)
            PH_RST_LOW:  cur_len = timing.reset_low;
            PH_RST_WAIT: cur_len = timing.presence_wait;
            PH_RST_TAIL: cur_len = timing.reset_tail;
            PH_WR_START: cur_len = timing.slot_start;
            PH_WR_HOLD:  cur_len = timing.write_slot;
            PH_RD_START: cur_len = timing.slot_start;
            PH_RD_WAIT:  cur_len = timing.read_sample;
            PH_RD_TAIL:  cur_len = timing.read_tail;
            default:     cur_len = {{(TimeW-1){1'b0}}, 1'b1};
        endcase
    end

    assign timer_inc = timer_reg + 1'b1;

    always_comb
    begin
        phase_next     = phase_reg;
        timer_next     = timer_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        first_next     = first_reg;
        presence_next  = presence_reg;
        done           = 1'b0;
        rejected       = 1'b0;
        rdata          = '0;

        if (phase_reg == PH_IDLE)
        begin
            if (item.mode != MODE_TICK)
            begin
                timer_next     = '0;
                bit_count_next = '0;
                case (item.mode)
                    MODE_RESET:
                    begin
                        phase_next = PH_RST_LOW;
                    end
                    MODE_WRITE:
                    begin
                        shift_next = item.data_byte;
                        phase_next = PH_WR_START;
                    end
                    default:
                    begin
                        shift_next = '0;
                        phase_next = PH_RD_START;
                    end
                endcase
            end
        end
        else
        begin
            rejected = (item.mode != MODE_TICK);
            if (timer_inc >= cur_len)
            begin
                timer_next = '0;
                case (phase_reg)
                    PH_RST_LOW:
                    begin
                        phase_next = PH_RST_WAIT;
                    end
                    PH_RST_WAIT:
                    begin
                        first_next = item.line_level;
                        phase_next = PH_RST_TAIL;
                    end
                    PH_RST_TAIL:
                    begin
                        presence_next = (item.line_level == first_reg);
                        phase_next    = PH_IDLE;
                        done          = 1'b1;
                    end
                    PH_WR_START:
                    begin
                        phase_next = PH_WR_HOLD;
                    end
                    PH_WR_HOLD:
                    begin
                        if (bit_count_reg == 3'd7)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            bit_count_next = bit_count_reg + 1'b1;
                            shift_next     = shift_reg >> 1;
                            phase_next     = PH_WR_START;
                        end
                    end
                    PH_RD_START:
                    begin
                        phase_next = PH_RD_WAIT;
                    end
                    PH_RD_WAIT:
                    begin
                        shift_next = {item.line_level, shift_reg[ByteW-1:1]};
                        phase_next = PH_RD_TAIL;
                    end
                    PH_RD_TAIL:
                    begin
                        if (bit_count_reg == 3'd7)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                            rdata      = shift_reg;
                        end
                        else
                        begin
                            bit_count_next = bit_count_reg + 1'b1;
                            phase_next     = PH_RD_START;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            else
            begin
                timer_next = timer_inc;
            end
        end
    end

    always_comb
    begin
        case (phase_next)
            PH_RST_LOW,
            PH_WR_START,
            PH_RD_START: drive = 1'b1;
            PH_WR_HOLD:  drive = ~shift_next[0];
            default:     drive = 1'b0;
        endcase
    end

    assign res.drive_low        = drive;
    assign res.busy_res         = (phase_next != PH_IDLE);
    assign res.done_res         = done;
    assign res.read_data        = rdata;
    assign res.no_presence      = presence_next;
    assign res.command_rejected = rejected;

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res.done_res |-> !res.busy_res)
        else $error("done reported while still busy");

    a_reject_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res.command_rejected |-> phase_reg != PH_IDLE)
        else $error("command rejected while idle");

    a_start_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && phase_reg == PH_IDLE && item.mode != MODE_TICK
        |=> phase_reg != PH_IDLE && timer_reg == '0)
        else $error("command not started from idle");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(phase_reg) && $stable(timer_reg) && $stable(shift_reg))
        else $error("state moved without an item");

endmodule

[hdl/one_wire_bus_master_unit.sv]
// Single-wire bus master, one item per microsecond tick. Each input item carries the
// command (tuser: 0 tick, 1 bus reset, 2 write byte, 3 read byte, taken only while idle)
// and the sampled line level; each item gives exactly one result with the drive level,
// busy, done, read data, presence status and a reject flag for commands sent while busy.
// One item is taken per clock cycle unless the output stalls; a result reaches m_tdata
// via the input register, then the result register; the state update for a tick is a
// single pass through the phase timer compare and the phase sequencer. Timing registers
// are written via the cfg port by the user, only while the block is idle (not enforced).
module one_wire_bus_master_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // data_byte[7:0], line_level[8], zero
    input  logic [1:0]                    s_tuser,   // mode[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // drive_low, busy_res, done_res,
                                                     // read_data[10:3], no_presence,
                                                     // command_rejected, zero
    input  logic                          cfg_we,
    input  logic [owbm_pkg::RegIdxW-1:0]  cfg_addr,
    input  logic [owbm_pkg::TimeW-1:0]    cfg_data
);
    import owbm_pkg::*;

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;
    logic       advance;
    result_t    res;
    timing_t    timing;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.mode       <= mode_t'(s_tuser);
            in_item_reg.data_byte  <= s_tdata[ByteW-1:0];
            in_item_reg.line_level <= s_tdata[ByteW];
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    owbm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .timing   (timing)
    );

    owbm_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .timing  (timing),
        .res     (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16-ResultW){1'b0}}, out_res_reg};

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room in the pipeline");

    a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after an item was processed");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_res_reg))
        else $error("pending result dropped or changed");

endmodule

[bench/one_wire_bus_master_unit_test.sv]
`timescale 1ns / 1ps

module one_wire_bus_master_unit_test;

    import owbm_pkg::*;

    localparam int                 NUM_TIMING     = REG_READ_TAIL + 1;
    localparam logic [RegIdxW-1:0] REG_UNUSED     = 3'd7;
    localparam int                 WATCHDOG_LIMIT = 1000;
    localparam int                 LONG_HOLD      = 300;
    localparam int                 MAX_PRINTS     = 50;

    typedef logic [TimeW-1:0] timing_set_t [NUM_TIMING];

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [15:0]         s_tdata;   // data_byte[7:0], line_level[8], zero
    logic [1:0]          s_tuser;   // mode[1:0]
    logic                m_tvalid;
    logic                m_tready;
    logic [15:0]         m_tdata;   // drive_low, busy_res, done_res, read_data[10:3],
                                    // no_presence, command_rejected, zero
    logic                cfg_we;
    logic [RegIdxW-1:0]  cfg_addr;
    logic [TimeW-1:0]    cfg_data;

    one_wire_bus_master_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // bus master state as predicted by the bench
    phase_t           bm_phase;
    logic [TimeW-1:0] bm_timer;
    logic [2:0]       bm_bit_count;
    logic [ByteW-1:0] bm_shift;
    logic             bm_first_sample;
    logic             bm_no_presence;
    logic [TimeW-1:0] bm_timing [NUM_TIMING];

    result_t predicted_ticks [$];
    int      err_count;
    int      tx_idle_pct;
    int      rx_idle_pct;
    bit      rx_hold_request;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [TimeW-1:0] phase_len(phase_t p);
        case (p)
            PH_RST_LOW:  return bm_timing[REG_RESET_LOW];
            PH_RST_WAIT: return bm_timing[REG_PRESENCE_WAIT];
            PH_RST_TAIL: return bm_timing[REG_RESET_TAIL];
            PH_WR_START: return bm_timing[REG_SLOT_START];
            PH_WR_HOLD:  return bm_timing[REG_WRITE_SLOT];
            PH_RD_START: return bm_timing[REG_SLOT_START];
            PH_RD_WAIT:  return bm_timing[REG_READ_SAMPLE];
            PH_RD_TAIL:  return bm_timing[REG_READ_TAIL];
            default:     return 10'd1;
        endcase
    endfunction

    function automatic void advance_bus_master(mode_t m, logic [ByteW-1:0] d, logic line);
        result_t r;
        r = '0;
        if (bm_phase == PH_IDLE)
        begin
            if (m != MODE_TICK)
            begin
                bm_timer     = '0;
                bm_bit_count = '0;
                case (m)
                    MODE_RESET: bm_phase = PH_RST_LOW;
                    MODE_WRITE:
                    begin
                        bm_shift = d;
                        bm_phase = PH_WR_START;
                    end
                    default:
                    begin
                        bm_shift = '0;
                        bm_phase = PH_RD_START;
                    end
                endcase
            end
        end
        else
        begin
            r.command_rejected = (m != MODE_TICK);
            bm_timer = bm_timer + 1'b1;
            if (bm_timer >= phase_len(bm_phase))
            begin
                bm_timer = '0;
                case (bm_phase)
                    PH_RST_LOW:  bm_phase = PH_RST_WAIT;
                    PH_RST_WAIT:
                    begin
                        bm_first_sample = line;
                        bm_phase        = PH_RST_TAIL;
                    end
                    PH_RST_TAIL:
                    begin
                        bm_no_presence = (line == bm_first_sample);
                        bm_phase       = PH_IDLE;
                        r.done_res     = 1'b1;
                    end
                    PH_WR_START: bm_phase = PH_WR_HOLD;
                    PH_WR_HOLD:
                    begin
                        if (bm_bit_count == 3'd7)
                        begin
                            bm_phase   = PH_IDLE;
                            r.done_res = 1'b1;
                        end
                        else
                        begin
                            bm_bit_count = bm_bit_count + 1'b1;
                            bm_shift     = bm_shift >> 1;
                            bm_phase     = PH_WR_START;
                        end
                    end
                    PH_RD_START: bm_phase = PH_RD_WAIT;
                    PH_RD_WAIT:
                    begin
                        bm_shift = {line, bm_shift[ByteW-1:1]};
                        bm_phase = PH_RD_TAIL;
                    end
                    PH_RD_TAIL:
                    begin
                        if (bm_bit_count == 3'd7)
                        begin
                            bm_phase    = PH_IDLE;
                            r.done_res  = 1'b1;
                            r.read_data = bm_shift;
                        end
                        else
                        begin
                            bm_bit_count = bm_bit_count + 1'b1;
                            bm_phase     = PH_RD_START;
                        end
                    end
                    default: bm_phase = PH_IDLE;
                endcase
            end
        end
        case (bm_phase)
            PH_RST_LOW, PH_WR_START, PH_RD_START: r.drive_low = 1'b1;
            PH_WR_HOLD: r.drive_low = ~bm_shift[0];
            default:    r.drive_low = 1'b0;
        endcase
        r.busy_res    = (bm_phase != PH_IDLE);
        r.no_presence = bm_no_presence;
        predicted_ticks.push_back(r);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (err_count < MAX_PRINTS)
            $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic check_tick(logic [15:0] word);
        result_t got;
        result_t want;
        if (predicted_ticks.size() == 0)
        begin
            report_mismatch("unexpected item", 32'(word), 0);
            return;
        end
        want = predicted_ticks.pop_front();
        got  = result_t'(word[ResultW-1:0]);
        if (got.drive_low !== want.drive_low)
            report_mismatch("drive_low", 32'(got.drive_low), 32'(want.drive_low));
        if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
        if (got.done_res !== want.done_res)
            report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
        if (got.read_data !== want.read_data)
            report_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
        if (got.no_presence !== want.no_presence)
            report_mismatch("no_presence", 32'(got.no_presence), 32'(want.no_presence));
        if (got.command_rejected !== want.command_rejected)
            report_mismatch("command_rejected", 32'(got.command_rejected),
                            32'(want.command_rejected));
        if (word[15:ResultW] !== '0)
            report_mismatch("padding", 32'(word[15:ResultW]), 0);
    endtask

    function automatic int draw_gap(int pct);
        if ($urandom_range(0, 99) < pct)
            return $urandom_range(0, 14);
        return 0;
    endfunction

    task automatic send_tick(mode_t m, logic [ByteW-1:0] d, logic line);
        int gap;
        gap = draw_gap(tx_idle_pct);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= {7'b0, line, d};
        do
            @(posedge clk);
        while (!s_tready);
        advance_bus_master(m, d, line);
    endtask

    function automatic mode_t any_command();
        return mode_t'($urandom_range(MODE_RESET, MODE_READ));
    endfunction

    // tick until the current command ends, optionally sprinkling rejected commands
    task automatic run_to_idle(bit with_rejects);
        mode_t m;
        while (bm_phase != PH_IDLE)
        begin
            m = (with_rejects && $urandom_range(0, 7) == 0) ? any_command() : MODE_TICK;
            send_tick(m, ByteW'($urandom), 1'($urandom));
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (predicted_ticks.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_timing(timing_set_t t);
        settle();
        for (int i = REG_RESET_LOW; i <= REG_UNUSED; i++)
        begin
            cfg_we   <= 1'b1;
            cfg_addr <= RegIdxW'(i);
            cfg_data <= (i == REG_UNUSED) ? '1 : t[i];
            @(posedge clk);
            if (i != REG_UNUSED)
                bm_timing[i] = t[i];
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_traffic(int n_items);
        mode_t m;
        for (int k = 0; k < n_items; k++)
        begin
            if (bm_phase == PH_IDLE)
                m = ($urandom_range(0, 9) < 8) ? any_command() : MODE_TICK;
            else
                m = ($urandom_range(0, 9) == 0) ? any_command() : MODE_TICK;
            send_tick(m, ByteW'($urandom), 1'($urandom));
        end
        run_to_idle(1'b0);
    endtask

    task automatic test_directed();
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        // write slot register zero: behaves as one tick
        apply_timing('{10'd1, 10'd1, 10'd1, 10'd1, 10'd0, 10'd1, 10'd1});
        send_tick(MODE_TICK, 8'hFF, 1'b1);
        send_tick(MODE_TICK, 8'h00, 1'b0);
        // device answers: presence samples differ; command on the done tick is rejected
        send_tick(MODE_RESET, 8'hFF, 1'b0);
        send_tick(MODE_TICK, 8'h00, 1'b0);
        send_tick(MODE_TICK, 8'h00, 1'b1);
        send_tick(MODE_READ, 8'h00, 1'b0);
        // nobody answers: samples equal
        send_tick(MODE_RESET, 8'h00, 1'b1);
        send_tick(MODE_TICK, 8'h00, 1'b1);
        send_tick(MODE_WRITE, 8'hFF, 1'b1);
        send_tick(MODE_TICK, 8'h00, 1'b1);
        send_tick(MODE_WRITE, 8'h00, 1'b1);
        run_to_idle(1'b1);
        send_tick(MODE_READ, 8'h5A, 1'b1);
        run_to_idle(1'b1);
    endtask

    task automatic test_short_timing();
        timing_set_t t;
        for (int p = 0; p < 4; p++)
        begin
            foreach (t[i])
                t[i] = TimeW'($urandom_range(0, 4));
            tx_idle_pct = (p == 0) ? 0 : $urandom_range(10, 70);
            rx_idle_pct = (p == 0) ? 0 : $urandom_range(10, 70);
            apply_timing(t);
            random_traffic(60);
        end
    endtask

    task automatic test_mid_timing();
        timing_set_t t;
        foreach (t[i])
            t[i] = TimeW'($urandom_range(1, 12));
        tx_idle_pct = 20;
        rx_idle_pct = 40;
        apply_timing(t);
        random_traffic(100);
    endtask

    task automatic test_default_timing();
        tx_idle_pct = 10;
        rx_idle_pct = 10;
        apply_timing('{RESET_LOW_DEF, PRESENCE_WAIT_DEF, RESET_TAIL_DEF, SLOT_START_DEF,
                       WRITE_SLOT_DEF, READ_SAMPLE_DEF, READ_TAIL_DEF});
        send_tick(MODE_WRITE, ByteW'($urandom), 1'($urandom));
        run_to_idle(1'b1);
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 20;
        apply_timing('{10'd2, 10'd2, 10'd2, 10'd2, 10'd2, 10'd2, 10'd2});
        rx_hold_request = 1'b1;
        random_traffic(100);
    endtask

    initial
    begin
        s_tvalid        <= 1'b0;
        s_tdata         <= '0;
        s_tuser         <= MODE_TICK;
        cfg_we          <= 1'b0;
        cfg_addr        <= '0;
        cfg_data        <= '0;
        rst_n           <= 1'b0;
        err_count       = 0;
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        rx_hold_request = 1'b0;
        bm_phase        = PH_IDLE;
        bm_timer        = '0;
        bm_bit_count    = '0;
        bm_shift        = '0;
        bm_first_sample = 1'b0;
        bm_no_presence  = 1'b0;
        bm_timing       = '{RESET_LOW_DEF, PRESENCE_WAIT_DEF, RESET_TAIL_DEF, SLOT_START_DEF,
                            WRITE_SLOT_DEF, READ_SAMPLE_DEF, READ_TAIL_DEF};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_short_timing();
        test_mid_timing();
        test_backpressure();
        test_default_timing();

        settle();
        repeat (10) @(posedge clk);
        if (predicted_ticks.size() != 0)
            report_mismatch("items never delivered", predicted_ticks.size(), 0);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int gap;
        m_tready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (rx_hold_request)
            begin
                gap             = LONG_HOLD;
                rx_hold_request = 1'b0;
            end
            else
                gap = draw_gap(rx_idle_pct);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            check_tick(m_tdata);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
hdl/owbm_pkg.sv
hdl/owbm_cfg.sv
hdl/owbm_fsm.sv
hdl/one_wire_bus_master_unit.sv
bench/one_wire_bus_master_unit_test.sv
